### hw/rtl/rsk_pkg.sv
// rsk_pkg: shared types, codes and the key compare for the keyed record sorter
// depends on nothing; imported by rsk_cell and record_sorter_by_selected_key_unit
`timescale 1ns / 1ps
`default_nettype none

package rsk_pkg;

  localparam int unsigned PidW   = 23;
  localparam int unsigned PrioW  = 9;
  localparam int unsigned NiceW  = 6;
  localparam int unsigned TagW   = 16;
  localparam int unsigned RecW   = PidW + PrioW + NiceW + TagW;
  localparam int unsigned TdataW = ((RecW + 7) / 8) * 8;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned ApbAddrW = 2;
  localparam int unsigned ApbDataW = 32;

  localparam logic [ApbAddrW-1:0] RegSortModeAddr = ApbAddrW'(0);

  typedef enum logic [ModeW-1:0] {
    MODE_KEEP = 2'd0,
    MODE_PID  = 2'd1,
    MODE_PRIO = 2'd2,
    MODE_NICE = 2'd3
  } sort_mode_e;

  typedef enum logic {
    ST_LOAD  = 1'b0,
    ST_DRAIN = 1'b1
  } rsk_state_e;

  typedef struct packed {
    logic [TagW-1:0]         tag;
    logic signed [NiceW-1:0] nice;
    logic signed [PrioW-1:0] prio;
    logic [PidW-1:0]         pid;
  } rec_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic       load;
    logic       shift;
    sort_mode_e mode;
  } rsk_ctrl_t;

  // strict compare: x moves ahead of y, so equal keys keep arrival order
  function automatic logic goes_before(sort_mode_e mode, rec_t x, rec_t y);
    logic res;
    unique case (mode)
      MODE_KEEP: res = 1'b0;
      MODE_PID:  res = (x.pid < y.pid);
      MODE_PRIO: res = ($signed(x.prio) > $signed(y.prio));
      MODE_NICE: res = ($signed(x.nice) > $signed(y.nice));
      default:   res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/record_sorter_by_selected_key_unit.sv
// record sorter: a chain of insertion cells keeps the set ordered while it loads.
// intake: one record per cycle, the new record is placed in the chain on the beat unless the chain is full.
// first sorted beat: offered in the cycle after the beat carrying tlast.
// output: n records leave as n beats, one shift of the cell chain per beat;
// no intake while a run drains. reset clears cell valid bits, mode, flag, fsm.
`timescale 1ns / 1ps
`default_nettype none

module record_sorter_by_selected_key_unit #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // apb configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rsk_pkg::ApbAddrW-1:0]    paddr,
  input  wire logic [rsk_pkg::ApbDataW-1:0]    pwdata,
  output logic      [rsk_pkg::ApbDataW-1:0]    prdata,
  output logic                                 pready,
  // input records
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // pid[22:0], priority_req[31:23], nice[37:32], tag[53:38], zero[55:54]
  input  wire logic [rsk_pkg::TdataW-1:0]      s_axis_tdata,
  input  wire logic                            s_axis_tlast,
  // sorted records
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // out_pid[22:0], out_priority[31:23], out_nice[37:32], out_tag[53:38], zero[55:54]
  output logic      [rsk_pkg::TdataW-1:0]      m_axis_tdata,
  output logic                                 m_axis_tlast,
  // overflow[0]
  output logic                                 m_axis_tuser
);
  import rsk_pkg::*;

  sort_mode_e mode_q;
  rsk_state_e state_q, state_d;
  logic       drop_q, drop_d;

  rec_t       new_rec;
  rsk_ctrl_t  ctrl;
  rec_t       cell_rec [MAX_RECORDS];
  logic [MAX_RECORDS-1:0] cell_valid;
  logic [MAX_RECORDS-1:0] cell_ins;

  logic s_fire, m_fire, full;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_KEEP;
    end else if (psel && penable && pwrite && pready && paddr == RegSortModeAddr) begin
      mode_q <= sort_mode_e'(pwdata[ModeW-1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == RegSortModeAddr) begin
      prdata = ApbDataW'(mode_q);
    end
  end

  // beat handling
  assign new_rec = rec_t'(s_axis_tdata[RecW-1:0]);
  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign m_fire  = m_axis_tvalid && m_axis_tready;
  assign full    = cell_valid[MAX_RECORDS-1];

  assign ctrl.load  = s_fire && !full;
  assign ctrl.shift = m_fire;
  assign ctrl.mode  = mode_q;

  // cell chain, cell 0 holds the head of the sorted run
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    rec_t prev_rec, next_rec;
    logic prev_valid, prev_ins, next_valid;

    if (i == 0) begin : g_first
      assign prev_rec   = new_rec;
      assign prev_valid = 1'b1;
      assign prev_ins   = 1'b0;
    end else begin : g_mid
      assign prev_rec   = cell_rec[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_ins   = cell_ins[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_last
      assign next_rec   = new_rec;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_rec   = cell_rec[i+1];
      assign next_valid = cell_valid[i+1];
    end

    rsk_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_rec_i    (new_rec),
      .prev_rec_i   (prev_rec),
      .prev_valid_i (prev_valid),
      .prev_ins_i   (prev_ins),
      .next_rec_i   (next_rec),
      .next_valid_i (next_valid),
      .rec_o        (cell_rec[i]),
      .valid_o      (cell_valid[i]),
      .ins_o        (cell_ins[i])
    );
  end

  // control fsm
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (s_fire && s_axis_tlast) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (m_fire && m_axis_tlast) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      ST_LOAD:  s_axis_tready = 1'b1;
      ST_DRAIN: m_axis_tvalid = 1'b1;
      default: begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
      end
    endcase
  end

  // drop flag lives for one set, cleared with the final beat of its run
  always_comb begin
    drop_d = drop_q;
    if (m_fire && m_axis_tlast) begin
      drop_d = 1'b0;
    end else if (s_fire && full) begin
      drop_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      drop_q  <= drop_d;
    end
  end

  assign m_axis_tdata = TdataW'(cell_rec[0]);
  assign m_axis_tlast = cell_valid[0] && !cell_valid[1];
  assign m_axis_tuser = drop_q;

`ifndef ASSERT_OFF
  a_one_side_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("intake and output open together");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> cell_valid[0])
    else $error("draining with an empty head cell");

  a_chain_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, cell_valid} + (MAX_RECORDS + 1)'(1)))
    else $error("gap in cell valid bits");

  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_fire && m_axis_tlast |=> s_axis_tready && !m_axis_tuser && !cell_valid[0])
    else $error("chain not empty after final beat");
`endif

endmodule

`default_nettype wire

### hw/rtl/rsk_cell.sv
// rsk_cell: one slot of the insertion chain, holds a record and its valid bit
// depends on rsk_pkg
`timescale 1ns / 1ps
`default_nettype none

module rsk_cell (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  rsk_pkg::rsk_ctrl_t    ctrl_i,
  input  rsk_pkg::rec_t         new_rec_i,
  input  rsk_pkg::rec_t         prev_rec_i,
  input  wire logic             prev_valid_i,
  input  wire logic             prev_ins_i,
  input  rsk_pkg::rec_t         next_rec_i,
  input  wire logic             next_valid_i,
  output rsk_pkg::rec_t         rec_o,
  output logic                  valid_o,
  output logic                  ins_o
);
  import rsk_pkg::*;

  rec_t rec_q, rec_d;
  logic valid_q, valid_d;

  // new record lands here or further down the chain, nearer the head
  assign ins_o = !valid_q || goes_before(ctrl_i.mode, new_rec_i, rec_q);

  always_comb begin
    rec_d   = rec_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      rec_d   = next_rec_i;
      valid_d = next_valid_i;
    end else if (ctrl_i.load && ins_o) begin
      // neighbour below also moves up: take its record, else the new one
      rec_d   = prev_ins_i ? prev_rec_i : new_rec_i;
      valid_d = valid_q | prev_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o   = rec_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire
